/* design/lis_pkg.sv */
package lis_pkg;

    localparam int MaxLights   = 256;
    localparam int SlotW       = 8;
    localparam int CountW      = 9;
    localparam int CoordW      = 24;
    localparam int PowerW      = 32;
    localparam int FracW       = 24;
    localparam int FloorW      = 50;
    localparam int WeightW     = 48;
    localparam int CumW        = 56;
    localparam int ProbW       = 25;

    localparam logic [0:0] CfgLightCount = 1'b0;
    localparam logic [0:0] CfgMinDist    = 1'b1;
    localparam logic       ActLoad       = 1'b0;
    localparam logic       ActSelect     = 1'b1;

    localparam logic [FloorW-1:0] FloorReset = FloorW'(16777);
    localparam logic [WeightW-1:0] WeightMax = '1;
    localparam logic [CumW-1:0]    CumMax    = '1;

    typedef struct packed {
        logic                     action;
        logic [SlotW-1:0]         light_slot;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic [PowerW-1:0]        light_power;
        logic [FracW-1:0]         random_fraction;
    } t_in_word;

    typedef struct packed {
        logic              found;
        logic [SlotW-1:0]  chosen_light;
        logic [ProbW-1:0]  choice_probability;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic             load_in;      // capture input word
        logic             write_light;  // write light tables
        logic             clear_cache;
        logic             start_rebuild;
        logic             rebuild_step;
        logic             start_search;
        logic             search_step;
        logic             start_div;
        logic             div_step;
        logic             finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_select;
        logic cache_hit;
        logic rebuild_done;
        logic search_done;
        logic div_done;
    } t_status;

endpackage

/* design/lis_ctrl.sv */
module lis_ctrl
    import lis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    input  t_status   i_status,
    output t_cmd      o_cmd
);

    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StDecode  = 3'd1;
    localparam logic [2:0] StRebuild = 3'd2;
    localparam logic [2:0] StSearch  = 3'd3;
    localparam logic [2:0] StDiv     = 3'd4;
    localparam logic [2:0] StOut     = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != StIdle);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            StIdle: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = StDecode;
                end
            end
            StDecode: begin
                if (!i_status.is_select) begin
                    o_cmd.write_light = 1'b1;
                    o_cmd.clear_cache = 1'b1;
                    n_state           = StIdle;
                end else if (i_status.cache_hit) begin
                    o_cmd.start_search = 1'b1;
                    n_state            = StSearch;
                end else begin
                    o_cmd.start_rebuild = 1'b1;
                    n_state             = StRebuild;
                end
            end
            StRebuild: begin
                if (i_status.rebuild_done) begin
                    o_cmd.start_search = 1'b1;
                    n_state            = StSearch;
                end else begin
                    o_cmd.rebuild_step = 1'b1;
                end
            end
            StSearch: begin
                if (i_status.search_done) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = StDiv;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            StDiv: begin
                if (i_status.div_done) begin
                    n_state = StOut;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            StOut: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> o_in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> out_free)
        else $error("result overwritten");

endmodule

/* design/lis_datapath.sv */
module lis_datapath
    import lis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in_word            i_in_data,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [FloorW-1:0]   i_cfg_data,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output t_out_word           o_out_data
);

    // light tables and caches
    logic [CoordW-1:0]  mem_x [MaxLights];
    logic [CoordW-1:0]  mem_y [MaxLights];
    logic [CoordW-1:0]  mem_z [MaxLights];
    logic [PowerW-1:0]  mem_p [MaxLights];
    logic [WeightW-1:0] mem_w [MaxLights];
    logic [CumW-1:0]    mem_c [MaxLights];

    t_in_word           r_in;
    logic [CountW-1:0]  r_count;
    logic [FloorW-1:0]  r_floor;
    logic [CoordW-1:0]  r_cx, r_cy, r_cz;
    logic [CumW-1:0]    r_sum;
    logic               r_lp_valid;
    logic [SlotW-1:0]   r_lp_slot;
    logic               r_cache_valid;

    logic [CountW-1:0]  active_n;
    assign active_n = (r_count > CountW'(MaxLights)) ? CountW'(MaxLights) : r_count;

    // ---------------- rebuild: read, square, sum, divide, accumulate ----
    localparam logic [2:0] RbRead = 3'd0;
    localparam logic [2:0] RbDiff = 3'd1;
    localparam logic [2:0] RbSq   = 3'd2;
    localparam logic [2:0] RbDen  = 3'd3;
    localparam logic [2:0] RbDiv  = 3'd4;
    localparam logic [2:0] RbAcc  = 3'd5;

    logic [2:0]          r_rb_ph;
    logic [CountW-1:0]   r_rb_idx;
    logic [CoordW-1:0]   r_rx, r_ry, r_rz;
    logic [PowerW-1:0]   r_rp;
    logic [CoordW:0]     r_dx, r_dy, r_dz;
    logic [FloorW-1:0]   r_sx, r_sy, r_sz;
    logic [FloorW-1:0]   r_den;
    logic [55:0]         r_dnum;   // power << 24, shifted out one bit a step
    logic [FloorW:0]     r_drem;
    logic [55:0]         r_dq;
    logic [5:0]          r_dcnt;
    logic                rb_busy;

    logic signed [CoordW:0] ex, ey, ez;
    logic [FloorW-1:0]   d2, fl;
    logic [FloorW:0]     rem_sh;
    logic [WeightW-1:0]  w_sat;
    logic [CumW:0]       cum_next;

    assign rb_busy = (r_rb_idx < active_n);
    assign ex = $signed({r_rx[CoordW-1], r_rx}) - $signed({r_in.coord_x[CoordW-1], r_in.coord_x});
    assign ey = $signed({r_ry[CoordW-1], r_ry}) - $signed({r_in.coord_y[CoordW-1], r_in.coord_y});
    assign ez = $signed({r_rz[CoordW-1], r_rz}) - $signed({r_in.coord_z[CoordW-1], r_in.coord_z});
    assign d2 = r_sx + r_sy + r_sz;
    assign fl = (r_floor == '0) ? FloorW'(1) : r_floor;
    assign rem_sh = {r_drem[FloorW-1:0], r_dnum[55]};
    assign w_sat = (r_dq[55:WeightW] != '0) ? WeightMax : r_dq[WeightW-1:0];
    assign cum_next = {1'b0, r_sum} + (CumW+1)'(w_sat);

    // ---------------- search: binary search over cumulative sums -------
    logic [CumW-1:0]    target;
    logic [CumW-1:0]    r_target;
    logic [CountW-1:0]  r_lo, r_hi;
    logic [SlotW-1:0]   mid;
    logic [CumW-1:0]    r_cum_rd;
    logic               r_rd_pend;
    logic [SlotW-1:0]   r_mid;
    logic [CumW+FracW-1:0] prod_hi, prod_lo;

    assign prod_hi = CumW'(r_sum >> FracW) * r_in.random_fraction;
    assign prod_lo = (CumW+FracW)'(r_sum[FracW-1:0]) * r_in.random_fraction;
    assign target  = prod_hi[CumW-1:0] + CumW'(prod_lo >> FracW);
    assign mid     = SlotW'((r_lo + r_hi) >> 1);

    // ---------------- ratio divider ------------------------------------
    logic [SlotW-1:0]   r_sel;
    logic               r_found;
    logic [WeightW-1:0] r_wsel;
    logic [CumW:0]      r_rrem;
    logic [ProbW-1:0]   r_rq;
    logic [4:0]         r_rcnt;
    logic               r_wsel_rd;
    logic [CumW:0]      rr_sh;

    assign rr_sh = {r_rrem[CumW-1:0], 1'b0};

    always_comb begin
        o_status.is_select    = (r_in.action == ActSelect);
        o_status.cache_hit    = r_cache_valid && r_cx == r_in.coord_x
                              && r_cy == r_in.coord_y && r_cz == r_in.coord_z;
        o_status.rebuild_done = !rb_busy && (r_rb_ph == RbRead);
        o_status.search_done  = !r_rd_pend && (r_lo >= r_hi);
        o_status.div_done     = !r_wsel_rd && (r_rcnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_data;
        if (i_cmd.write_light) begin
            mem_x[r_in.light_slot] <= r_in.coord_x;
            mem_y[r_in.light_slot] <= r_in.coord_y;
            mem_z[r_in.light_slot] <= r_in.coord_z;
            mem_p[r_in.light_slot] <= r_in.light_power;
        end
        if (i_cmd.rebuild_step && r_rb_ph == RbRead && rb_busy) begin
            r_rx <= mem_x[r_rb_idx[SlotW-1:0]];
            r_ry <= mem_y[r_rb_idx[SlotW-1:0]];
            r_rz <= mem_z[r_rb_idx[SlotW-1:0]];
            r_rp <= mem_p[r_rb_idx[SlotW-1:0]];
        end
        if (i_cmd.rebuild_step && r_rb_ph == RbAcc) begin
            mem_w[r_rb_idx[SlotW-1:0]] <= w_sat;
            mem_c[r_rb_idx[SlotW-1:0]] <= cum_next[CumW] ? CumMax : cum_next[CumW-1:0];
        end
        if (i_cmd.search_step && !r_rd_pend) r_cum_rd <= mem_c[mid];
        if (r_wsel_rd) r_wsel  <= mem_w[r_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_floor       <= FloorReset;
            r_cx          <= '0;
            r_cy          <= '0;
            r_cz          <= '0;
            r_sum         <= '0;
            r_lp_valid    <= 1'b0;
            r_lp_slot     <= '0;
            r_cache_valid <= 1'b0;
            r_rb_ph       <= RbRead;
            r_rb_idx      <= '0;
            r_rd_pend     <= 1'b0;
            r_wsel_rd     <= 1'b0;
            r_rcnt        <= '0;
            r_lo          <= '0;
            r_hi          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgLightCount: r_count <= i_cfg_data[CountW-1:0];
                    CfgMinDist:    r_floor <= i_cfg_data;
                    default: ;
                endcase
                r_cache_valid <= 1'b0;
            end
            if (i_cmd.clear_cache) r_cache_valid <= 1'b0;

            if (i_cmd.start_rebuild) begin
                r_rb_idx   <= '0;
                r_rb_ph    <= RbRead;
                r_sum      <= '0;
                r_lp_valid <= 1'b0;
                r_lp_slot  <= '0;
            end
            if (i_cmd.rebuild_step) begin
                case (r_rb_ph)
                    RbRead: r_rb_ph <= RbDiff;
                    RbDiff: begin
                        r_dx <= ex[CoordW] ? $unsigned(-ex) : $unsigned(ex);
                        r_dy <= ey[CoordW] ? $unsigned(-ey) : $unsigned(ey);
                        r_dz <= ez[CoordW] ? $unsigned(-ez) : $unsigned(ez);
                        r_rb_ph <= RbSq;
                    end
                    RbSq: begin
                        r_sx <= r_dx * r_dx;
                        r_sy <= r_dy * r_dy;
                        r_sz <= r_dz * r_dz;
                        r_rb_ph <= RbDen;
                    end
                    RbDen: begin
                        r_den  <= (d2 > fl) ? d2 : fl;
                        r_dnum <= {r_rp, 24'd0};
                        r_drem <= '0;
                        r_dq   <= '0;
                        r_dcnt <= 6'd56;
                        r_rb_ph <= RbDiv;
                    end
                    RbDiv: begin
                        if (r_dcnt == '0) begin
                            r_rb_ph <= RbAcc;
                        end else begin
                            r_dnum <= {r_dnum[54:0], 1'b0};
                            if (rem_sh >= {1'b0, r_den}) begin
                                r_drem <= rem_sh - {1'b0, r_den};
                                r_dq   <= {r_dq[54:0], 1'b1};
                            end else begin
                                r_drem <= rem_sh;
                                r_dq   <= {r_dq[54:0], 1'b0};
                            end
                            r_dcnt <= r_dcnt - 6'd1;
                        end
                    end
                    RbAcc: begin
                        r_sum <= cum_next[CumW] ? CumMax : cum_next[CumW-1:0];
                        if (w_sat != '0) begin
                            r_lp_valid <= 1'b1;
                            r_lp_slot  <= r_rb_idx[SlotW-1:0];
                        end
                        r_rb_idx <= r_rb_idx + CountW'(1);
                        r_rb_ph  <= RbRead;
                    end
                    default: r_rb_ph <= RbRead;
                endcase
            end
            if (i_cmd.start_search) begin
                if (!i_cmd.rebuild_step && !o_status.cache_hit) begin
                    r_cx <= r_in.coord_x;
                    r_cy <= r_in.coord_y;
                    r_cz <= r_in.coord_z;
                    r_cache_valid <= 1'b1;
                end
                r_target  <= target;
                r_lo      <= '0;
                r_hi      <= active_n;
                r_rd_pend <= 1'b0;
            end
            if (i_cmd.search_step) begin
                if (!r_rd_pend) begin
                    r_mid     <= mid;
                    r_rd_pend <= 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                    if (r_cum_rd > r_target) r_hi <= {1'b0, r_mid};
                    else                     r_lo <= {1'b0, r_mid} + CountW'(1);
                end
            end
            if (i_cmd.start_div) begin
                if (r_lo < active_n) begin
                    r_sel   <= r_lo[SlotW-1:0];
                    r_found <= 1'b1;
                end else begin
                    r_sel   <= r_lp_slot;
                    r_found <= r_lp_valid;
                end
                r_wsel_rd <= 1'b1;
                r_rcnt    <= 5'd0;
            end
            if (i_cmd.div_step) begin
                if (r_wsel_rd) begin
                    r_wsel_rd <= 1'b0;
                    r_rcnt    <= 5'd25;
                    r_rq      <= '0;
                    r_rrem    <= '0;
                end else if (r_rcnt == 5'd25) begin
                    // weight <= total: integer quotient is 0 or 1
                    if ({8'd0, r_wsel} >= r_sum) begin
                        r_rrem <= {1'b0, CumW'(r_wsel) - r_sum};
                        r_rq   <= ProbW'(1);
                    end else begin
                        r_rrem <= {1'b0, CumW'(r_wsel)};
                    end
                    r_rcnt <= r_rcnt - 5'd1;
                end else begin
                    if (rr_sh >= {1'b0, r_sum}) begin
                        r_rrem <= rr_sh - {1'b0, r_sum};
                        r_rq   <= {r_rq[ProbW-2:0], 1'b1};
                    end else begin
                        r_rrem <= rr_sh;
                        r_rq   <= {r_rq[ProbW-2:0], 1'b0};
                    end
                    r_rcnt <= r_rcnt - 5'd1;
                end
            end
        end
    end

    always_comb begin
        if (r_sum == '0 || !r_found) begin
            o_out_data = '0;
        end else begin
            o_out_data.found              = 1'b1;
            o_out_data.chosen_light       = r_sel;
            o_out_data.choice_probability = r_rq;
        end
    end

    a_rb_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rb_idx <= CountW'(MaxLights))
        else $error("rebuild index past table");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search_step |-> r_lo <= r_hi)
        else $error("search bounds crossed");
    a_cache_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_cache |=> !r_cache_valid)
        else $error("cache not cleared on load");

endmodule

/* design/light_importance_selector_core.sv */
// Weighted light picker. Load words (action 0) write one light's centre and
// power and clear the weight cache; a load produces no result. A select word
// (action 1) returns one result word. When the shading point matches the
// cached point the select runs a binary search over the cumulative table
// (each probe reads, then compares, over one memory port) plus a 25-step
// serial divide for the probability. On a cache miss each active light is
// first weighted again through a 56-step serial weight divider. Writing a
// register clears the cache; configure only while idle.
module light_importance_selector_core
    import lis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [FloorW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_data
);

    t_cmd      cmd;
    t_status   status;
    t_out_word dp_out;
    t_out_word r_out;

    lis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lis_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (dp_out)
    );

    always_ff @(posedge i_clk) begin
        if (cmd.finish) r_out <= dp_out;
    end

    assign o_out_data = r_out;

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import lis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_index = CfgLightCount;
    logic [FloorW-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_data;

    light_importance_selector_core dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [CoordW-1:0] lamp_x [MaxLights];
    logic signed [CoordW-1:0] lamp_y [MaxLights];
    logic signed [CoordW-1:0] lamp_z [MaxLights];
    logic [PowerW-1:0]        lamp_power [MaxLights];
    longint unsigned          lamp_weight [MaxLights];
    longint unsigned          running_sum [MaxLights];
    logic [CountW-1:0]        cur_count = '0;
    logic [FloorW-1:0]        cur_floor = FloorReset;
    t_in_word                 cached_pt;
    logic                     cache_ok = 1'b0;
    longint unsigned          grand_total;
    int                       last_lit;

    // generator-side bookkeeping
    bit                       slot_loaded [MaxLights];
    t_in_word                 pending_words [$];
    t_out_word                expected_picks [$];
    int                       n_errors = 0;
    int                       in_idle_pct = 37;
    int                       out_idle_pct = 37;
    int                       quiet_cycles = 0;

    function automatic int lights_in_use();
        return (cur_count > MaxLights) ? MaxLights : int'(cur_count);
    endfunction

    function automatic void rebuild_weights(t_in_word w);
        longint signed   dx, dy, dz;
        longint unsigned d2, fl, den, q, acc;
        acc = 0;
        last_lit = -1;
        fl = (cur_floor == 0) ? 64'd1 : 64'(cur_floor);
        for (int i = 0; i < lights_in_use(); i++) begin
            dx = longint'(lamp_x[i]) - longint'(w.coord_x);
            dy = longint'(lamp_y[i]) - longint'(w.coord_y);
            dz = longint'(lamp_z[i]) - longint'(w.coord_z);
            d2 = dx * dx + dy * dy + dz * dz;
            den = (d2 > fl) ? d2 : fl;
            q = (64'(lamp_power[i]) << 24) / den;
            if (q > 64'(WeightMax)) q = 64'(WeightMax);
            lamp_weight[i] = q;
            acc = (64'(CumMax) - acc < q) ? 64'(CumMax) : acc + q;
            running_sum[i] = acc;
            if (q > 0) last_lit = i;
        end
        grand_total = acc;
        cached_pt = w;
        cache_ok = 1'b1;
    endfunction

    function automatic t_out_word pick_light(t_in_word w);
        t_out_word       r;
        longint unsigned tgt, fr;
        logic [87:0]     num;
        int              sel;
        r = '0;
        if (!cache_ok || cached_pt.coord_x != w.coord_x || cached_pt.coord_y != w.coord_y
            || cached_pt.coord_z != w.coord_z) begin
            rebuild_weights(w);
        end
        if (grand_total == 0) return r;
        fr = 64'(w.random_fraction);
        tgt = (grand_total >> 24) * fr + (((grand_total & 64'hFFFFFF) * fr) >> 24);
        sel = -1;
        for (int i = 0; i < lights_in_use(); i++) begin
            if (running_sum[i] > tgt) begin
                sel = i;
                break;
            end
        end
        if (sel < 0) sel = last_lit;
        if (sel < 0) return r;
        num = 88'(lamp_weight[sel]) << 24;
        r.found = 1'b1;
        r.chosen_light = sel[SlotW-1:0];
        r.choice_probability = ProbW'(num / grand_total);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_in_data.action == ActLoad) begin
                    lamp_x[i_in_data.light_slot] = i_in_data.coord_x;
                    lamp_y[i_in_data.light_slot] = i_in_data.coord_y;
                    lamp_z[i_in_data.light_slot] = i_in_data.coord_z;
                    lamp_power[i_in_data.light_slot] = i_in_data.light_power;
                    cache_ok = 1'b0;
                end else begin
                    expected_picks = {expected_picks, pick_light(i_in_data)};
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: unexpected result word %p", $realtime, o_out_data);
                    n_errors++;
                end else begin
                    want = expected_picks.pop_front();
                    if (o_out_data.found !== want.found) begin
                        $display("%0t: found exp %0d got %0d", $realtime,
                                 want.found, o_out_data.found);
                        n_errors++;
                    end
                    if (o_out_data.chosen_light !== want.chosen_light) begin
                        $display("%0t: chosen_light exp %0d got %0d", $realtime,
                                 want.chosen_light, o_out_data.chosen_light);
                        n_errors++;
                    end
                    if (o_out_data.choice_probability !== want.choice_probability) begin
                        $display("%0t: choice_probability exp %h got %h", $realtime,
                                 want.choice_probability, o_out_data.choice_probability);
                        n_errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("** light_importance_selector_core: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [FloorW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgLightCount) cur_count = val[CountW-1:0];
        else cur_floor = val;
        cache_ok = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || expected_picks.size() != 0)
            @(posedge i_clk);
        // a trailing load gives no result; let it drain
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_load(int slot, int cx, int cy, int cz, logic [PowerW-1:0] pw);
        t_in_word w;
        w = '0;
        w.action = ActLoad;
        w.light_slot = slot[SlotW-1:0];
        w.coord_x = cx[CoordW-1:0];
        w.coord_y = cy[CoordW-1:0];
        w.coord_z = cz[CoordW-1:0];
        w.light_power = pw;
        w.random_fraction = FracW'($urandom);
        slot_loaded[slot] = 1'b1;
        pending_words = {pending_words, w};
    endtask

    task automatic push_select(int cx, int cy, int cz, logic [FracW-1:0] fr);
        t_in_word w;
        w = '0;
        w.action = ActSelect;
        w.light_slot = SlotW'($urandom);
        w.coord_x = cx[CoordW-1:0];
        w.coord_y = cy[CoordW-1:0];
        w.coord_z = cz[CoordW-1:0];
        w.light_power = PowerW'($urandom);
        w.random_fraction = fr;
        pending_words = {pending_words, w};
    endtask

    function automatic int near_coord();
        return ($urandom_range(9) == 0) ? int'($urandom) : $urandom_range(16384) - 8192;
    endfunction

    function automatic logic [PowerW-1:0] rand_power();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PowerW'($urandom);
        endcase
    endfunction

    initial begin
        int n_lights, n_words, pool_x[3], pool_y[3], pool_z[3], k;
        logic [FloorW-1:0] fl;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no lights: nothing found
        push_select(0, 0, 0, '1);
        wait_idle();

        // four lights, two at the coordinate extremes, one dark
        write_reg(CfgLightCount, FloorW'(4));
        push_load(0, 0, 0, 0, '0);
        push_load(1, 8388607, 8388607, 8388607, '1);
        push_load(2, -8388608, -8388608, -8388608, PowerW'(32'h0001_0000));
        push_load(3, 4096, -4096, 0, PowerW'(32'h0100_0000));
        push_select(0, 0, 0, '0);
        push_select(0, 0, 0, '1);
        push_select(0, 0, 0, FracW'(24'h800000));
        push_select(8388607, 8388607, 8388607, FracW'(24'h000001));
        push_select(-8388608, -8388608, -8388608, FracW'(24'hFFFFFE));
        wait_idle();

        // zero floor acts as one; light hit dead on saturates its weight
        write_reg(CfgMinDist, '0);
        push_select(4096, -4096, 0, '1);
        push_select(4096, -4096, 0, '0);
        push_select(4096, -4096, 0, FracW'(24'h7FFFFF));
        wait_idle();
        write_reg(CfgMinDist, '1);
        push_select(1, 2, 3, FracW'(24'h123456));
        // all weights zero
        push_load(1, 0, 0, 0, '0);
        push_load(2, 0, 0, 0, '0);
        push_load(3, 0, 0, 0, '0);
        push_select(1, 2, 3, FracW'(24'h123456));
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            in_idle_pct = (ph == 4) ? 0 : 37;
            out_idle_pct = (ph == 4) ? 0 : 37;
            case (ph)
                6:       n_lights = 256;
                11:      n_lights = 511;
                default: n_lights = $urandom_range(8, 1);
            endcase
            case ($urandom_range(4))
                0:       fl = '0;
                1:       fl = '1;
                2:       fl = FloorReset;
                3:       fl = FloorW'(1);
                default: fl = FloorW'({$urandom, $urandom});
            endcase
            write_reg(CfgLightCount, FloorW'(n_lights));
            write_reg(CfgMinDist, fl);
            k = (n_lights > MaxLights) ? MaxLights : n_lights;
            for (int s = 0; s < k; s++)
                if (!slot_loaded[s])
                    push_load(s, near_coord(), near_coord(), near_coord(), rand_power());
            for (int p = 0; p < 3; p++) begin
                pool_x[p] = near_coord();
                pool_y[p] = near_coord();
                pool_z[p] = near_coord();
            end
            // big tables rebuild slowly: few words, mostly cache hits
            n_words = (k > 8) ? 8 : 28;
            for (int j = 0; j < n_words; j++) begin
                if (k <= 8 && $urandom_range(4) == 0) begin
                    push_load($urandom_range(k - 1), near_coord(), near_coord(),
                              near_coord(), rand_power());
                end else if ($urandom_range(5) == 0 && k <= 8) begin
                    push_select(int'($urandom), int'($urandom), int'($urandom),
                                FracW'($urandom));
                end else begin
                    k = (n_lights > MaxLights) ? MaxLights : n_lights;
                    j = j;
                    push_select(pool_x[j % 3 == 0 ? $urandom_range(2) : 0],
                                pool_y[0], pool_z[0], FracW'($urandom));
                end
            end
            wait_idle();
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && expected_picks.size() == 0) begin
            $display("** light_importance_selector_core: PASSED **");
        end else begin
            $display("** light_importance_selector_core: FAILED **");
        end
        $finish;
    end

endmodule

/* light_importance_selector_core.f */
design/lis_pkg.sv
design/lis_ctrl.sv
design/lis_datapath.sv
design/light_importance_selector_core.sv
tb/sv/testbench.sv
